@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/tdpb_pkg.sv @@
// ----------------------------------------------------------------------------
// tdpb_pkg
// Shared widths, reset values and codes for the tail-drop packet buffer.
// ----------------------------------------------------------------------------
package tdpb_pkg;

    localparam int TIME_W        = 40;
    localparam int ARR_W         = 32;
    localparam int PT_W          = 16;
    localparam int CAP_W         = 7;
    localparam int MAX_DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    typedef enum logic
    {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EVAL,
        ST_POP,
        ST_DONE
    } state_t;

endpackage

@@ rtl/tdpb_if.sv @@
// ----------------------------------------------------------------------------
// tdpb_if
// Valid/ready channels for packets in and results out.
// ----------------------------------------------------------------------------
interface tdpb_pkt_if
    import tdpb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ARR_W-1:0]  arr_stamp;
    logic [PT_W-1:0]   svc_len;

    modport source (output valid, output arr_stamp, output svc_len, input ready);
    modport sink   (input valid, input arr_stamp, input svc_len, output ready);
endinterface

interface tdpb_res_if
    import tdpb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              dropped;
    logic [TIME_W-1:0] start_stamp;

    modport source (output valid, output dropped, output start_stamp, input ready);
    modport sink   (input valid, input dropped, input start_stamp, output ready);
endinterface

@@ rtl/tdpb_ring.sv @@
// ----------------------------------------------------------------------------
// tdpb_ring
// Finish-time ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdpb_ring
    import tdpb_pkg::*;
#(
    parameter int DEPTH = MAX_DEPTH_DEF,
    parameter int IDX_W = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [TIME_W-1:0] wdata,
    input  logic              re,
    input  logic [IDX_W-1:0]  raddr,
    output logic [TIME_W-1:0] rdata
);

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tdpb_alu.sv @@
// ----------------------------------------------------------------------------
// tdpb_alu
// Shared 41-bit adder: compare (a <= b) by subtraction, or saturating add.
// ----------------------------------------------------------------------------
module tdpb_alu
    import tdpb_pkg::*;
(
    input  alu_op_t           op,
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output logic              le,
    output logic [TIME_W-1:0] sum_sat
);

    logic [TIME_W-1:0] a_opnd;
    logic [TIME_W:0]   total;

    // b - a = b + ~a + 1; carry out set means no borrow, i.e. a <= b
    assign a_opnd  = (op == ALU_SUB) ? ~a : a;
    assign total   = {1'b0, b} + {1'b0, a_opnd} + {{TIME_W{1'b0}}, (op == ALU_SUB)};
    assign le      = total[TIME_W];
    assign sum_sat = total[TIME_W] ? TIME_MAX : total[TIME_W-1:0];

endmodule

@@ rtl/tail_drop_packet_buffer_unit.sv @@
// Sequence: an input transfer moves IDLE to EVAL; a cleared ring goes on to DONE,
//   otherwise POP pops finished entries (one per cycle) before DONE, which registers
//   the result once the output is free. The single ring read port and the shared
//   adder set the pop rate. Not ready while busy.
// Reset: rst_n async low; ring empty, capacity 64, ring memory not cleared.
// ----------------------------------------------------------------------------
// tail_drop_packet_buffer_unit
// Single-server packet buffer with tail drop, run by a small sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tail_drop_packet_buffer_unit
    import tdpb_pkg::*;
#(
    parameter int MAX_DEPTH = MAX_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    tdpb_pkt_if.sink          pkt_in,
    tdpb_res_if.source        res_out,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int OCC_W = $clog2(MAX_DEPTH + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int SUM_W = ((OCC_W > IDX_W) ? OCC_W : IDX_W) + 1;

    state_t            state_reg, state_next;
    logic [ARR_W-1:0]  arr_reg;
    logic [PT_W-1:0]   pt_reg;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] last_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic              out_valid_reg;
    logic              out_drop_reg;
    logic [TIME_W-1:0] out_start_reg;

    logic              accept;
    logic              out_free;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [TIME_W-1:0] rd_data;
    alu_op_t           alu_op;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic              alu_le;
    logic [TIME_W-1:0] alu_sum;
    logic              clear;
    logic              pop;
    logic              finish;
    logic              push;
    logic              drop;
    logic [IDX_W-1:0]  head_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_idx;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  cap_eff;

    assign accept   = pkt_in.valid && pkt_in.ready;
    assign out_free = !out_valid_reg || res_out.ready;

    assign head_inc = (head_reg == IDX_W'(MAX_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    // head + occ < 2 * depth, so one conditional subtract wraps it
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(occ_reg);
    assign tail_idx = (tail_sum >= SUM_W'(MAX_DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(MAX_DEPTH)) : IDX_W'(tail_sum);

    assign cap_ext = CMP_W'(cap_reg);
    assign cap_eff = (cap_ext > CMP_W'(MAX_DEPTH)) ? CMP_W'(MAX_DEPTH) : cap_ext;
    assign drop    = (CMP_W'(occ_reg) >= cap_eff);

    tdpb_ring #(
        .DEPTH (MAX_DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk   (clk),
        .we    (push),
        .waddr (tail_idx),
        .wdata (alu_sum),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tdpb_alu u_alu (
        .op      (alu_op),
        .a       (alu_a),
        .b       (alu_b),
        .le      (alu_le),
        .sum_sat (alu_sum)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pkt_in.valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = clear ? ST_DONE : ST_POP;
            end
            ST_POP:
            begin
                if (!pop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: shared adder operands, ring read, update strobes
    always_comb
    begin
        pkt_in.ready = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = head_reg;
        alu_op       = ALU_SUB;
        alu_a        = last_reg;
        alu_b        = TIME_W'(arr_reg);
        clear        = 1'b0;
        pop          = 1'b0;
        finish       = 1'b0;
        push         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pkt_in.ready = 1'b1;
                rd_en        = pkt_in.valid;
            end
            ST_EVAL:
            begin
                clear = (occ_reg == '0) || alu_le;
            end
            ST_POP:
            begin
                alu_a   = rd_data;
                pop     = (occ_reg != '0) && alu_le;
                rd_en   = pop;
                rd_addr = head_inc;
            end
            ST_DONE:
            begin
                alu_op = ALU_ADD;
                alu_a  = start_reg;
                alu_b  = TIME_W'(pt_reg);
                finish = out_free;
                push   = out_free && !drop;
            end
            default:
            begin
                pkt_in.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            last_reg      <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (clear)
            begin
                head_reg <= '0;
                occ_reg  <= '0;
            end
            else if (pop)
            begin
                head_reg <= head_inc;
                occ_reg  <= occ_reg - 1'b1;
            end
            else if (push)
            begin
                occ_reg  <= occ_reg + 1'b1;
                last_reg <= alu_sum;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arr_reg <= pkt_in.arr_stamp;
            pt_reg  <= pkt_in.svc_len;
        end
        if (state_reg == ST_EVAL)
        begin
            start_reg <= clear ? TIME_W'(arr_reg) : last_reg;
        end
        if (finish)
        begin
            out_drop_reg  <= drop;
            out_start_reg <= start_reg;
        end
    end

    assign res_out.valid       = out_valid_reg;
    assign res_out.dropped     = out_drop_reg;
    assign res_out.start_stamp = out_start_reg;

    `ASSERT_SAME(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= OCC_W'(MAX_DEPTH))
    `ASSERT_SAME(a_push_room, clk, rst_n, push, CMP_W'(occ_reg) < cap_eff)
    `ASSERT_NEXT(a_pop_dec, clk, rst_n, pop, occ_reg == $past(occ_reg) - 1'b1)
    `ASSERT_NEXT(a_accept_eval, clk, rst_n, accept, state_reg == ST_EVAL)

endmodule
